// ===== hdl/keqmd_pkg.sv =====
// Shared types and constants for the key event queue and modifier decoder.
// Depends on nothing; every other file of the block uses it.
`timescale 1ns / 1ps

package keqmd_pkg;

	localparam int QUEUE_DEPTH_DEF = 128;

	localparam int CODE_W   = 10;
	localparam int VALUE_W  = 32;
	localparam int BIASED_W = 14;

	// Opcodes of an input item.
	localparam logic [1:0] OP_INJECT = 2'd0;
	localparam logic [1:0] OP_POLL   = 2'd1;
	localparam logic [1:0] OP_RECORD = 2'd2;

	localparam logic [15:0] RECORD_TYPE_KEY = 16'd1;

	typedef struct packed {
		logic [1:0]                opcode;
		logic [15:0]               record_type;
		logic [CODE_W-1:0]         key_code;
		logic signed [VALUE_W-1:0] key_value;
	} in_item_t;

	typedef struct packed {
		logic                      accepted;
		logic                      key_found;
		logic [BIASED_W-1:0]       biased_code;
		logic signed [VALUE_W-1:0] event_value;
	} out_item_t;

	// One queued event.
	typedef struct packed {
		logic [CODE_W-1:0]         code;
		logic signed [VALUE_W-1:0] value;
	} entry_t;

	// Request from the control logic to the decoder.
	typedef struct packed {
		logic                      strobe;
		logic [CODE_W-1:0]         code;
		logic signed [VALUE_W-1:0] value;
	} dec_req_t;

	typedef struct packed {
		logic                found;
		logic [BIASED_W-1:0] biased_code;
	} dec_res_t;

endpackage

// ===== hdl/keqmd_decoder.sv =====
// Modifier decoder: holds the shift, ctrl, alt and caps lock flags and turns a
// key event into a biased code. Depends on keqmd_pkg.
`timescale 1ns / 1ps

module keqmd_decoder (
	input  logic                clk,
	input  logic                arst_n,
	input  keqmd_pkg::dec_req_t req,
	output keqmd_pkg::dec_res_t res
);
	import keqmd_pkg::*;

	localparam logic [CODE_W-1:0] KEY_LSHIFT = 10'd42;
	localparam logic [CODE_W-1:0] KEY_RSHIFT = 10'd54;
	localparam logic [CODE_W-1:0] KEY_LCTRL  = 10'd29;
	localparam logic [CODE_W-1:0] KEY_RCTRL  = 10'd97;
	localparam logic [CODE_W-1:0] KEY_LALT   = 10'd56;
	localparam logic [CODE_W-1:0] KEY_RALT   = 10'd100;
	localparam logic [CODE_W-1:0] KEY_CAPS   = 10'd58;

	localparam logic [VALUE_W-1:0] VAL_RELEASE = 32'd0;
	localparam logic [VALUE_W-1:0] VAL_PRESS   = 32'd1;
	localparam logic [VALUE_W-1:0] VAL_REPEAT  = 32'd2;

	localparam logic [BIASED_W-1:0] BIAS_SHIFT = 14'd1000;
	localparam logic [BIASED_W-1:0] BIAS_CTRL  = 14'd4000;
	localparam logic [BIASED_W-1:0] BIAS_ALT   = 14'd8000;

	logic shift_q, ctrl_q, alt_q, caps_q;
	logic is_shift, is_ctrl, is_alt, is_caps, is_letter;
	logic [VALUE_W-1:0] val;
	logic held, sh;
	logic [BIASED_W-1:0] bias;

	assign val       = req.value;
	assign is_shift  = (req.code == KEY_LSHIFT) || (req.code == KEY_RSHIFT);
	assign is_ctrl   = (req.code == KEY_LCTRL) || (req.code == KEY_RCTRL);
	assign is_alt    = (req.code == KEY_LALT) || (req.code == KEY_RALT);
	assign is_caps   = (req.code == KEY_CAPS);
	assign is_letter = req.code inside {[10'd16:10'd25], [10'd30:10'd38], [10'd44:10'd50]};
	assign held      = (val != VAL_RELEASE);

	always_comb begin
		// Caps lock swaps the shift bias, for letters only.
		sh   = shift_q ^ (caps_q && is_letter);
		bias = (sh ? BIAS_SHIFT : '0) + (ctrl_q ? BIAS_CTRL : '0) + (alt_q ? BIAS_ALT : '0);
		res.found       = !(is_shift || is_ctrl || is_alt || is_caps);
		res.biased_code = {{(BIASED_W - CODE_W){1'b0}}, req.code} + bias;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= 1'b0;
			ctrl_q  <= 1'b0;
			alt_q   <= 1'b0;
			caps_q  <= 1'b0;
		end else if (req.strobe) begin
			// A repeat leaves the modifier flags alone.
			if (is_shift && val != VAL_REPEAT) shift_q <= held;
			if (is_ctrl && val != VAL_REPEAT) ctrl_q <= held;
			if (is_alt && val != VAL_REPEAT) alt_q <= held;
			if (is_caps && val == VAL_PRESS) caps_q <= !caps_q;
		end
	end

endmodule

// ===== hdl/key_event_queue_modifier_decoder.sv =====
// Top level of the key event queue: event ring memory, pointers, control
// sequencer and output register. Depends on keqmd_pkg and keqmd_decoder.
`timescale 1ns / 1ps

// Every input item gives exactly one result. An inject or a device record is
// taken in ST_IDLE, the state of its transfer, and its result is then loaded
// into the output register from ST_FIN. A poll that reads n queued entries uses
// the single read port of the event ring, which delivers one entry per cycle,
// and the decoder handles each entry in the cycle after the read. One item is in
// work at a time; a finished result that cannot enter a stalled output register
// holds the block in ST_FIN until the waiting result leaves. A full ring drops
// its oldest event on inject; the ring holds at most QUEUE_DEPTH - 1 events.
// No clearing pass is needed after reset.
module key_event_queue_modifier_decoder #(
	parameter int QUEUE_DEPTH = keqmd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  keqmd_pkg::in_item_t  in_item,
	output logic                 out_valid,
	input  logic                 out_stall,
	output keqmd_pkg::out_item_t out_item,
	input  logic                 cfg_wr_en,
	input  logic                 cfg_wr_data
);
	import keqmd_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_READ = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	state_t state_q;
	logic [PTR_W-1:0] rd_ptr_q, wr_ptr_q, rd_next, wr_next;
	logic inj_en_q;
	logic out_valid_q;
	out_item_t res_q, out_q;

	entry_t mem [QUEUE_DEPTH];
	entry_t rdata_q;
	logic mem_we, mem_re;

	dec_req_t dec_req;
	dec_res_t dec_res;

	logic in_xfer, empty, out_free, is_key_rec;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign in_stall   = (state_q != ST_IDLE);
	assign in_xfer    = in_valid && !in_stall;
	assign empty      = (rd_ptr_q == wr_ptr_q);
	assign out_free   = !out_valid_q || !out_stall;
	assign rd_next    = ptr_inc(rd_ptr_q);
	assign wr_next    = ptr_inc(wr_ptr_q);
	assign is_key_rec = (in_item.opcode == OP_RECORD) && (in_item.record_type == RECORD_TYPE_KEY);
	assign out_valid  = out_valid_q;
	assign out_item   = out_q;

	assign mem_we = in_xfer && (in_item.opcode == OP_INJECT) && inj_en_q;
	assign mem_re = (in_xfer && (in_item.opcode == OP_POLL) && !empty)
		|| ((state_q == ST_READ) && !dec_res.found && !empty);

	// The decoder sees either the device record or the entry just read.
	always_comb begin
		if (state_q == ST_READ) begin
			dec_req.strobe = 1'b1;
			dec_req.code   = rdata_q.code;
			dec_req.value  = rdata_q.value;
		end else begin
			dec_req.strobe = in_xfer && is_key_rec;
			dec_req.code   = in_item.key_code;
			dec_req.value  = in_item.key_value;
		end
	end

	keqmd_decoder u_decoder (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dec_req),
		.res    (dec_res)
	);

	always_ff @(posedge clk) begin
		if (mem_we) mem[wr_ptr_q] <= '{code: in_item.key_code, value: in_item.key_value};
		if (mem_re) rdata_q <= mem[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_ptr_q    <= '0;
			wr_ptr_q    <= '0;
			inj_en_q    <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) inj_en_q <= cfg_wr_data;
			if (state_q == ST_FIN && out_free) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= mem_re ? ST_READ : ST_FIN;
						if (mem_we) begin
							wr_ptr_q <= wr_next;
							// A full ring loses its oldest event.
							if (wr_next == rd_ptr_q) rd_ptr_q <= rd_next;
						end
						if (mem_re) rd_ptr_q <= rd_next;
					end
				end
				ST_READ: begin
					if (mem_re) rd_ptr_q <= rd_next;
					else state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_xfer) begin
			res_q.accepted    <= mem_we;
			res_q.key_found   <= is_key_rec && dec_res.found;
			res_q.biased_code <= (is_key_rec && dec_res.found) ? dec_res.biased_code : '0;
			res_q.event_value <= (is_key_rec && dec_res.found) ? in_item.key_value : '0;
		end else if (state_q == ST_READ) begin
			res_q.accepted    <= 1'b0;
			res_q.key_found   <= dec_res.found;
			res_q.biased_code <= dec_res.found ? dec_res.biased_code : '0;
			res_q.event_value <= dec_res.found ? rdata_q.value : '0;
		end
		if (state_q == ST_FIN && out_free) out_q <= res_q;
	end

endmodule

// ===== hdl/keqmd_checker.sv =====
// Port-level checks for the key event queue, bound to the top level.
// Depends on keqmd_pkg and key_event_queue_modifier_decoder.
`timescale 1ns / 1ps

module keqmd_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input keqmd_pkg::out_item_t out_item
);

	// A stalled result holds until its transfer.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	// Only one item is in work: an input transfer is followed by a busy cycle.
	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item taken while the first was in work");

	// An inject never delivers a key.
	a_accept_no_key: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.accepted |-> !out_item.key_found)
		else $error("inject result carries a key");

	// Without a key the code and value fields are zero.
	a_zero_no_key: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.key_found |->
			out_item.biased_code == '0 && out_item.event_value == '0)
		else $error("result without a key has nonzero fields");

endmodule

bind key_event_queue_modifier_decoder keqmd_checker u_keqmd_checker (.*);
